// ----- hdl/i2c_mbc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_mbc_pkg
// Shared types, constants and the phase table of the byte-level I2C master.
// ----------------------------------------------------------------------------
package i2c_mbc_pkg;

  localparam int unsigned DelayW = 16;
  localparam int unsigned IdxW   = 5;

  localparam logic [DelayW-1:0] DEFAULT_DELAY = 16'd32;

  typedef enum logic [2:0] {
    CMD_IDLE      = 3'd0,
    CMD_START     = 3'd1,
    CMD_STOP      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_READ_ACK  = 3'd4,
    CMD_READ_NACK = 3'd5
  } cmd_t;

  // one pin phase: which line moves, its new level, and whether SDA is sampled
  typedef struct packed {
    logic is_sda;
    logic level;
    logic samples;
  } phase_t;

  function automatic logic [IdxW-1:0] phase_count(input cmd_t cmd);
    logic [IdxW-1:0] cnt;
    case (cmd)
      CMD_START:     cnt = 5'd4;
      CMD_STOP:      cnt = 5'd3;
      CMD_WRITE:     cnt = 5'd28;
      CMD_READ_ACK,
      CMD_READ_NACK: cnt = 5'd22;
      default:       cnt = 5'd0;
    endcase
    return cnt;
  endfunction

  function automatic phase_t phase_act(input cmd_t cmd, input logic [IdxW-1:0] idx,
                                       input logic [7:0] shift);
    phase_t p;
    p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
    case (cmd)
      CMD_START: begin
        case (idx)
          5'd0:    p = '{is_sda: 1'b1, level: 1'b1, samples: 1'b0};
          5'd1:    p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
          5'd2:    p = '{is_sda: 1'b1, level: 1'b0, samples: 1'b0};
          5'd3:    p = '{is_sda: 1'b0, level: 1'b0, samples: 1'b0};
          default: p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
        endcase
      end
      CMD_STOP: begin
        case (idx)
          5'd0:    p = '{is_sda: 1'b1, level: 1'b0, samples: 1'b0};
          5'd1:    p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
          5'd2:    p = '{is_sda: 1'b1, level: 1'b1, samples: 1'b0};
          default: p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
        endcase
      end
      CMD_WRITE: begin
        // three phases per data bit, msb first, then the ack slot
        case (idx)
          5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24:
                   p = '{is_sda: 1'b0, level: 1'b0, samples: 1'b0};
          5'd1:    p = '{is_sda: 1'b1, level: shift[7], samples: 1'b0};
          5'd4:    p = '{is_sda: 1'b1, level: shift[6], samples: 1'b0};
          5'd7:    p = '{is_sda: 1'b1, level: shift[5], samples: 1'b0};
          5'd10:   p = '{is_sda: 1'b1, level: shift[4], samples: 1'b0};
          5'd13:   p = '{is_sda: 1'b1, level: shift[3], samples: 1'b0};
          5'd16:   p = '{is_sda: 1'b1, level: shift[2], samples: 1'b0};
          5'd19:   p = '{is_sda: 1'b1, level: shift[1], samples: 1'b0};
          5'd22:   p = '{is_sda: 1'b1, level: shift[0], samples: 1'b0};
          5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd23:
                   p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
          5'd25:   p = '{is_sda: 1'b1, level: 1'b1, samples: 1'b0};
          5'd26:   p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b1};
          default: p = '{is_sda: 1'b0, level: 1'b0, samples: 1'b0};
        endcase
      end
      CMD_READ_ACK, CMD_READ_NACK: begin
        if (idx == 5'd0) begin
          p = '{is_sda: 1'b1, level: 1'b1, samples: 1'b0};
        end else if (idx <= 5'd16) begin
          // odd phases pull scl low, even phases release it and sample
          p = '{is_sda: 1'b0, level: ~idx[0], samples: ~idx[0]};
        end else begin
          case (idx)
            5'd17:   p = '{is_sda: 1'b0, level: 1'b0, samples: 1'b0};
            5'd18:   p = '{is_sda: 1'b1, level: (cmd != CMD_READ_ACK), samples: 1'b0};
            5'd19:   p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
            5'd20:   p = '{is_sda: 1'b0, level: 1'b0, samples: 1'b0};
            default: p = '{is_sda: 1'b1, level: 1'b1, samples: 1'b0};
          endcase
        end
      end
      default: p = '{is_sda: 1'b0, level: 1'b1, samples: 1'b0};
    endcase
    return p;
  endfunction

endpackage

// ----- hdl/i2c_master_byte_controller.sv -----
`timescale 1ns / 1ps
// a request is taken into the input register and, after one step of the bus sequencer,
// is loaded into the result register, which holds it while out_ready is low
// throughput: one request per cycle unless out_ready stalls; each is one bus step
// reset: synchronous active-low rst_n clears the sequencer, releases both lines
// and empties the input and result registers
// ----------------------------------------------------------------------------
// i2c_master_byte_controller
// Byte-level open-drain I2C master: start, stop, byte write and byte read.
// ----------------------------------------------------------------------------
module i2c_master_byte_controller
  import i2c_mbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_sda_in,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_ready_res,
  output logic        out_done_res,
  output logic        out_ack_received,
  output logic [7:0]  out_read_data
);

  logic [DelayW-1:0] phase_delay_r;

  // input register
  logic       s1_valid_r;
  logic [2:0] s1_kind_r;
  logic [7:0] s1_tx_r;
  logic       s1_sda_r;

  // sequencer state
  cmd_t              cmd_r, cmd_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [DelayW-1:0] timer_r, timer_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic              scl_r, scl_nxt;
  logic              sda_r, sda_nxt;
  logic              ack_r, ack_nxt;
  logic              done_pulse_r, done_pulse_nxt;
  logic [7:0]        read_byte_r, read_byte_nxt;

  // result register
  logic       out_valid_r;
  logic       res_scl_r, res_sda_r, res_ready_r, res_done_r, res_ack_r;
  logic [7:0] res_rd_r;

  logic              advance;
  logic              idle;
  logic [DelayW-1:0] delay_w;
  logic              res_scl_nxt, res_sda_nxt;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign idle     = (cmd_r == CMD_IDLE);
  assign delay_w  = (phase_delay_r == '0) ? DEFAULT_DELAY : phase_delay_r;

  always_comb begin
    cmd_t            cmd_a;
    logic [IdxW-1:0] idx_a;
    logic [IdxW-1:0] idx_inc;
    logic [DelayW-1:0] timer_a;
    logic [7:0]      shift_a;
    logic            scl_a, sda_a;
    phase_t          act_a, act_b, act_c;

    cmd_a   = cmd_r;
    idx_a   = idx_r;
    timer_a = timer_r;
    shift_a = shift_r;
    scl_a   = scl_r;
    sda_a   = sda_r;

    // take a new command and enter its first phase
    if (idle && (s1_kind_r inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ_ACK,
                                   CMD_READ_NACK})) begin
      cmd_a   = cmd_t'(s1_kind_r);
      idx_a   = '0;
      shift_a = (cmd_t'(s1_kind_r) == CMD_WRITE) ? s1_tx_r : 8'd0;
      act_a   = phase_act(cmd_a, idx_a, shift_a);
      if (act_a.is_sda) sda_a = act_a.level;
      else              scl_a = act_a.level;
      timer_a = delay_w;
    end else begin
      act_a = '0;
    end

    cmd_nxt        = cmd_a;
    idx_nxt        = idx_a;
    timer_nxt      = timer_a;
    shift_nxt      = shift_a;
    scl_nxt        = scl_a;
    sda_nxt        = sda_a;
    ack_nxt        = ack_r;
    done_pulse_nxt = 1'b0;
    read_byte_nxt  = read_byte_r;
    idx_inc        = idx_a + 5'd1;
    act_b          = phase_act(cmd_a, idx_a, shift_a);
    act_c          = '0;

    if (cmd_a != CMD_IDLE) begin
      if (timer_a <= 16'd1) begin
        if (act_b.samples) begin
          if (cmd_a == CMD_WRITE) ack_nxt = ~s1_sda_r;
          else                    shift_nxt = {shift_a[6:0], s1_sda_r};
        end
        if (idx_inc >= phase_count(cmd_a)) begin
          if (cmd_a == CMD_READ_ACK || cmd_a == CMD_READ_NACK) read_byte_nxt = shift_nxt;
          cmd_nxt        = CMD_IDLE;
          idx_nxt        = '0;
          timer_nxt      = '0;
          done_pulse_nxt = 1'b1;
        end else begin
          idx_nxt = idx_inc;
          act_c   = phase_act(cmd_a, idx_inc, shift_nxt);
          if (act_c.is_sda) sda_nxt = act_c.level;
          else              scl_nxt = act_c.level;
          timer_nxt = delay_w;
        end
      end else begin
        timer_nxt = timer_a - 16'd1;
      end
    end

    // line levels of this cycle are those after a new command is taken
    res_scl_nxt = scl_a;
    res_sda_nxt = sda_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_delay_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      cmd_r         <= CMD_IDLE;
      idx_r         <= '0;
      timer_r       <= '0;
      shift_r       <= '0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      ack_r         <= 1'b0;
      done_pulse_r  <= 1'b0;
      read_byte_r   <= '0;
    end else begin
      if (cfg_wr_en) phase_delay_r <= cfg_wr_data;
      s1_valid_r  <= (in_valid && in_ready) || (s1_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && !out_ready);
      if (advance) begin
        cmd_r        <= cmd_nxt;
        idx_r        <= idx_nxt;
        timer_r      <= timer_nxt;
        shift_r      <= shift_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        ack_r        <= ack_nxt;
        done_pulse_r <= done_pulse_nxt;
        read_byte_r  <= read_byte_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_tx_r   <= in_tx_byte;
      s1_sda_r  <= in_sda_in;
    end
    if (advance) begin
      res_scl_r   <= res_scl_nxt;
      res_sda_r   <= res_sda_nxt;
      res_ready_r <= idle;
      res_done_r  <= done_pulse_r;
      res_ack_r   <= ack_nxt;
      res_rd_r    <= read_byte_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_scl_out      = res_scl_r;
  assign out_sda_out      = res_sda_r;
  assign out_ready_res    = res_ready_r;
  assign out_done_res     = res_done_r;
  assign out_ack_received = res_ack_r;
  assign out_read_data    = res_rd_r;

`ifndef SYNTHESIS
  a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == CMD_IDLE) |-> (timer_r == '0))
    else $error("timer running while sequencer idle");

  a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_pulse_r |-> (cmd_r == CMD_IDLE))
    else $error("done pulse while a command is active");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != CMD_IDLE) |-> (idx_r < phase_count(cmd_r)))
    else $error("phase index beyond command length");

  a_step_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed request lost before result register");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte-level I2C master requests cycle by cycle, predicts every bus
// cycle from its own model of the phase sequencer, and checks each result.
// ----------------------------------------------------------------------------
module testbench;
  import i2c_mbc_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  typedef enum int {SDA_RANDOM, SDA_LOW, SDA_HIGH} sda_pol_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       rdy;
    logic       done;
    logic       ack;
    logic [7:0] rdata;
  } bus_result_t;

  class bus_cycle_model;
    cmd_t        cmd;
    int          idx;
    int          timer;
    logic [7:0]  shreg;
    logic        scl_q;
    logic        sda_q;
    logic        ack_q;
    logic        done_q;
    logic [7:0]  rbyte;
    logic [15:0] delay;
    bus_result_t expected_cycles[$];
    int          errors;
    int          mismatches;

    function new();
      cmd = CMD_IDLE;
      idx = 0;
      timer = 0;
      shreg = 8'h00;
      scl_q = 1'b1;
      sda_q = 1'b1;
      ack_q = 1'b0;
      done_q = 1'b0;
      rbyte = 8'h00;
      delay = 16'h0000;
      errors = 0;
      mismatches = 0;
    endfunction

    function void set_delay(logic [15:0] v);
      delay = v;
    endfunction

    function bit busy();
      return cmd != CMD_IDLE;
    endfunction

    function int pending();
      return expected_cycles.size();
    endfunction

    function int phase_len();
      case (cmd)
        CMD_START:                   return 4;
        CMD_STOP:                    return 3;
        CMD_WRITE:                   return 28;
        CMD_READ_ACK, CMD_READ_NACK: return 22;
        default:                     return 0;
      endcase
    endfunction

    // which line the phase moves, to what level, and whether sda is sampled
    function bit phase_for(int i, output logic on_sda, output logic lvl);
      bit smp;
      int b;
      int r;
      smp = 1'b0;
      on_sda = 1'b0;
      lvl = 1'b1;
      b = i / 3;
      r = i % 3;
      case (cmd)
        CMD_START: begin
          if (i == 0 || i == 2) on_sda = 1'b1;
          if (i >= 2) lvl = 1'b0;
        end
        CMD_STOP: begin
          if (i != 1) on_sda = 1'b1;
          if (i == 0) lvl = 1'b0;
        end
        CMD_WRITE: begin
          if (i < 24) begin
            if (r == 0) begin
              lvl = 1'b0;
            end else if (r == 1) begin
              on_sda = 1'b1;
              lvl = shreg[7-b];
            end
          end else if (i == 25) begin
            on_sda = 1'b1;
          end else if (i == 26) begin
            smp = 1'b1;
          end else begin
            lvl = 1'b0;
          end
        end
        CMD_READ_ACK, CMD_READ_NACK: begin
          if (i == 0) begin
            on_sda = 1'b1;
          end else if (i <= 16) begin
            lvl = ((i - 1) % 2) != 0;
            smp = lvl;
          end else if (i == 18) begin
            on_sda = 1'b1;
            lvl = (cmd == CMD_READ_NACK);
          end else if (i == 17 || i == 20) begin
            lvl = 1'b0;
          end else if (i == 21) begin
            on_sda = 1'b1;
          end
        end
        default: ;
      endcase
      return smp;
    endfunction

    function void load_phase();
      logic on_sda;
      logic lvl;
      void'(phase_for(idx, on_sda, lvl));
      if (on_sda) sda_q = lvl;
      else scl_q = lvl;
      timer = (delay != 0) ? int'(delay) : int'(DEFAULT_DELAY);
    endfunction

    function void note_request(logic [2:0] kind, logic [7:0] tx, logic sda_in);
      bus_result_t r;
      logic        on_sda;
      logic        lvl;
      bit          smp;
      r.rdy = (cmd == CMD_IDLE);
      r.done = done_q;
      done_q = 1'b0;
      if (r.rdy && kind >= CMD_START && kind <= CMD_READ_NACK) begin
        cmd = cmd_t'(kind);
        idx = 0;
        shreg = (cmd == CMD_WRITE) ? tx : 8'h00;
        load_phase();
      end
      r.scl = scl_q;
      r.sda = sda_q;
      if (cmd != CMD_IDLE) begin
        smp = phase_for(idx, on_sda, lvl);
        if (timer <= 1) begin
          if (smp) begin
            if (cmd == CMD_WRITE) ack_q = ~sda_in;
            else shreg = {shreg[6:0], sda_in};
          end
          idx++;
          if (idx >= phase_len()) begin
            if (cmd == CMD_READ_ACK || cmd == CMD_READ_NACK) rbyte = shreg;
            cmd = CMD_IDLE;
            idx = 0;
            timer = 0;
            done_q = 1'b1;
          end else begin
            load_phase();
          end
        end else begin
          timer--;
        end
      end
      r.ack = ack_q;
      r.rdata = rbyte;
      expected_cycles.push_back(r);
    endfunction

    function void check_cycle(bus_result_t got);
      bus_result_t exp;
      if (expected_cycles.size() == 0) begin
        errors++;
        $display("%0t: bus cycle result with no request outstanding", $time);
        return;
      end
      exp = expected_cycles.pop_front();
      if (got.scl !== exp.scl || got.sda !== exp.sda || got.rdy !== exp.rdy ||
          got.done !== exp.done || got.ack !== exp.ack || got.rdata !== exp.rdata) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp scl=%b sda=%b rdy=%b done=%b ack=%b data=%h",
                   $time, exp.scl, exp.sda, exp.rdy, exp.done, exp.ack, exp.rdata);
          $display("%0t:          got scl=%b sda=%b rdy=%b done=%b ack=%b data=%h",
                   $time, got.scl, got.sda, got.rdy, got.done, got.ack, got.rdata);
        end
      end
    endfunction

    function void check_drained();
      if (expected_cycles.size() != 0) begin
        errors++;
        $display("%0d predicted bus cycles never came out", expected_cycles.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = CMD_IDLE;
  logic [7:0]  in_tx_byte = 8'h00;
  logic        in_sda_in = 1'b1;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_scl_out;
  logic        out_sda_out;
  logic        out_ready_res;
  logic        out_done_res;
  logic        out_ack_received;
  logic [7:0]  out_read_data;

  bus_cycle_model bus;
  bus_result_t    seen_cycle;
  int             tx_idle_pct = 23;
  int             rx_idle_pct = 61;
  int             items_sent;
  bit             hold_req = 1'b0;
  int             hold_left = 0;

  i2c_master_byte_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_tx_byte       (in_tx_byte),
    .in_sda_in        (in_sda_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_scl_out      (out_scl_out),
    .out_sda_out      (out_sda_out),
    .out_ready_res    (out_ready_res),
    .out_done_res     (out_done_res),
    .out_ack_received (out_ack_received),
    .out_read_data    (out_read_data)
  );

  assign seen_cycle = '{scl: out_scl_out, sda: out_sda_out, rdy: out_ready_res,
                        done: out_done_res, ack: out_ack_received, rdata: out_read_data};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) bus.check_cycle(seen_cycle);
  end

  function automatic logic pick_sda(sda_pol_t p);
    case (p)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(1));
    endcase
  endfunction

  // mostly idle cycles, sometimes a command that lands on a busy bus
  function automatic logic [2:0] fill_kind();
    if ($urandom_range(99) < 20) return 3'($urandom_range(7));
    return CMD_IDLE;
  endfunction

  task automatic send_item(input logic [2:0] k, input logic [7:0] tx, input logic sda);
    int gap;
    in_valid <= 1'b1;
    in_kind <= k;
    in_tx_byte <= tx;
    in_sda_in <= sda;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    bus.note_request(k, tx, sda);
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle(input sda_pol_t p);
    while (bus.busy()) send_item(fill_kind(), 8'($urandom), pick_sda(p));
  endtask

  task automatic issue(input logic [2:0] k, input logic [7:0] tx, input sda_pol_t p);
    send_item(k, tx, pick_sda(p));
    settle(p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (bus.pending() != 0);
  endtask

  task automatic set_phase_delay(input logic [15:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    bus.set_delay(v);
  endtask

  task automatic run_transaction();
    logic [7:0] addr;
    int         ops;
    int         n;
    n = $urandom_range(3);
    repeat (n) send_item(($urandom_range(3) == 0) ? KIND_SPARE_HI : CMD_IDLE,
                         8'($urandom), 1'($urandom_range(1)));
    if ($urandom_range(99) < 75) begin
      issue(CMD_START, 8'($urandom), SDA_RANDOM);
      repeat (($urandom_range(4) == 0) ? 2 : 1) begin
        addr = 8'($urandom);
        issue(CMD_WRITE, addr, SDA_RANDOM);
        ops = $urandom_range(1, 3);
        for (int i = 0; i < ops; i++) begin
          if (!addr[0]) issue(CMD_WRITE, 8'($urandom), SDA_RANDOM);
          else if (i < ops - 1) issue(CMD_READ_ACK, 8'($urandom), SDA_RANDOM);
          else issue(CMD_READ_NACK, 8'($urandom), SDA_RANDOM);
        end
        // a second pass through the loop is a repeated start
        issue(CMD_START, 8'($urandom), SDA_RANDOM);
      end
      if ($urandom_range(9) != 0) issue(CMD_STOP, 8'($urandom), SDA_RANDOM);
    end else begin
      // out-of-order commands and spare kinds
      repeat ($urandom_range(1, 4)) issue(3'($urandom_range(7)), 8'($urandom), SDA_RANDOM);
    end
  endtask

  task automatic random_phase(input int target);
    items_sent = 0;
    while (items_sent < target) run_transaction();
  endtask

  initial begin
    bus = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // short pass at the reset phase length
    send_item(CMD_IDLE, 8'hFF, 1'b1);
    send_item(KIND_SPARE_LO, 8'h00, 1'b0);
    send_item(KIND_SPARE_HI, 8'hFF, 1'b1);
    issue(CMD_START, 8'h00, SDA_RANDOM);
    issue(CMD_STOP, 8'h00, SDA_RANDOM);

    // directed pass at the shortest phase length
    set_phase_delay(16'd1);
    issue(CMD_START, 8'h00, SDA_RANDOM);
    issue(CMD_WRITE, 8'hFF, SDA_LOW);
    issue(CMD_WRITE, 8'h00, SDA_HIGH);
    issue(CMD_WRITE, 8'hA5, SDA_RANDOM);
    issue(CMD_READ_ACK, 8'hFF, SDA_HIGH);
    issue(CMD_READ_NACK, 8'h00, SDA_LOW);
    issue(CMD_READ_ACK, 8'h5A, SDA_RANDOM);
    issue(CMD_STOP, 8'h00, SDA_RANDOM);
    issue(CMD_STOP, 8'hFF, SDA_RANDOM);
    issue(CMD_READ_NACK, 8'h00, SDA_HIGH);
    issue(CMD_START, 8'h00, SDA_RANDOM);
    issue(CMD_START, 8'h00, SDA_RANDOM);
    issue(CMD_STOP, 8'h00, SDA_RANDOM);

    random_phase(400);

    tx_idle_pct = 61;
    rx_idle_pct = 23;
    set_phase_delay(16'd3);
    random_phase(400);

    // zero written back selects the default phase length again
    set_phase_delay(16'd0);
    issue(CMD_START, 8'h00, SDA_RANDOM);
    issue(CMD_STOP, 8'h00, SDA_RANDOM);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_phase_delay(16'd2);
    hold_req = 1'b1;
    random_phase(400);

    // long phase, then shortened from the next phase on
    set_phase_delay(16'd60);
    send_item(CMD_START, 8'h00, 1'b1);
    repeat (20) send_item(CMD_IDLE, 8'($urandom), 1'($urandom_range(1)));
    set_phase_delay(16'd1);
    settle(SDA_RANDOM);
    issue(CMD_STOP, 8'h00, SDA_RANDOM);

    drain();
    repeat (20) @(posedge clk);
    bus.check_drained();
    if (bus.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
